[rtl/process_scheduler_fifo_rr_sjf_defines.svh]
// Assertion macros shared by the scheduler checker.
// Needs signals named clk and rst_n in the scope of each use.
`ifndef PROCESS_SCHEDULER_FIFO_RR_SJF_DEFINES_SVH
`define PROCESS_SCHEDULER_FIFO_RR_SJF_DEFINES_SVH

// Implication in the same cycle.
`define PSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the next cycle.
`define PSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/psf_pkg.sv]
// Package for the job scheduler: policy codes, defaults, picker control.
// No dependencies.
package psf_pkg;

  localparam int MAX_JOBS_DEF  = 16;
  localparam int TIME_BITS_DEF = 32;

  localparam logic [1:0]  POL_FIFO = 2'd0;
  localparam logic [1:0]  POL_RR   = 2'd1;
  localparam logic [1:0]  POL_NSJF = 2'd2;
  localparam logic [1:0]  POL_PSJF = 2'd3;

  localparam logic [1:0]  REG_POLICY    = 2'd0;
  localparam logic [1:0]  REG_SLICE     = 2'd1;
  localparam logic [1:0]  REG_JOB_COUNT = 2'd2;

  localparam logic [15:0] SLICE_RESET     = 16'd500;
  localparam logic [4:0]  JOB_COUNT_RESET = 5'd16;

  localparam logic        OP_LOAD = 1'b0;

  typedef struct packed {
    logic clear;
    logic step;
    logic elig;
    logic after;
  } pick_ctl_t;

  typedef struct packed {
    logic have_min;
    logic have_first;
    logic have_after;
  } pick_flags_t;

endpackage

[rtl/psf_pick.sv]
// Slot picker: tracks minimum key, first eligible and first eligible
// at or after the rotation start over a stream of slots. Uses psf_pkg.
module psf_pick import psf_pkg::*; #(
  parameter int MAX_JOBS  = MAX_JOBS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pick_ctl_t                   ctl,
  input  logic [$clog2(MAX_JOBS)-1:0] idx,
  input  logic [TIME_BITS-1:0]        key,
  output pick_flags_t                 flags,
  output logic [$clog2(MAX_JOBS)-1:0] min_idx,
  output logic [$clog2(MAX_JOBS)-1:0] first_idx,
  output logic [$clog2(MAX_JOBS)-1:0] after_idx
);
  localparam int IDXW = $clog2(MAX_JOBS);

  pick_flags_t          flags_r;
  logic [IDXW-1:0]      min_idx_r, first_idx_r, after_idx_r;
  logic [TIME_BITS-1:0] min_key_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      flags_r <= '0;
    end else if (ctl.step && ctl.elig) begin
      if (!flags_r.have_min || key < min_key_r) begin
        flags_r.have_min <= 1'b1;
      end
      if (!flags_r.have_first) begin
        flags_r.have_first <= 1'b1;
      end
      if (ctl.after && !flags_r.have_after) begin
        flags_r.have_after <= 1'b1;
      end
    end
  end

  // strict compare keeps ties on the lowest slot
  always_ff @(posedge clk) begin
    if (ctl.step && ctl.elig) begin
      if (!flags_r.have_min || key < min_key_r) begin
        min_idx_r <= idx;
        min_key_r <= key;
      end
      if (!flags_r.have_first) begin
        first_idx_r <= idx;
      end
      if (ctl.after && !flags_r.have_after) begin
        after_idx_r <= idx;
      end
    end
  end

  assign flags     = flags_r;
  assign min_idx   = min_idx_r;
  assign first_idx = first_idx_r;
  assign after_idx = after_idx_r;

endmodule

[rtl/process_scheduler_fifo_rr_sjf.sv]
// Job scheduler (FIFO, round robin, non-preemptive and preemptive SJF). Load requests fill
// table slots in order; a tick request retires the running job if its time is spent, marks
// jobs whose ready time equals the current time as arrived, picks the job to run (ties to
// the lowest slot), and decrements it. Ready and remaining times sit in one memory with a
// write port and a registered read port; the scan of a tick reads each slot in use once,
// one per cycle. A tick steps through retire, reduction of the rotation start (the slot
// after the running one) below n for n slots in use by subtracting n (once when the
// running slot is the last slot in use, more often when job_count was cut below it), the
// slot scan, pick, decrement and result. A tick that retires the last job skips from retire
// to the result; a load, and a tick after all jobs are done, go straight to the result.
// A result still waiting in the result register stalls the next result, and so the input,
// until it is taken. One result per request; the result register lets the next request in.
// Depends on psf_pkg and psf_pick.
module process_scheduler_fifo_rr_sjf import psf_pkg::*; #(
  parameter int MAX_JOBS  = MAX_JOBS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [31:0] in_ready_at,
  input  logic [31:0] in_run_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_running_valid,
  output logic [3:0]  out_running_slot,
  output logic        out_switched,
  output logic        out_finished_valid,
  output logic [3:0]  out_finished_slot,
  output logic        out_all_done,
  output logic [31:0] out_tick_now,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int IDXW = $clog2(MAX_JOBS);
  localparam int CNTW = $clog2(MAX_JOBS + 1);
  localparam int EW   = 2 * TIME_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RET  = 3'd1;
  localparam logic [2:0] ST_MOD  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_PICK = 3'd4;
  localparam logic [2:0] ST_DEC  = 3'd5;
  localparam logic [2:0] ST_DECW = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  // configuration
  logic [1:0]  policy_r;
  logic [15:0] slice_r;
  logic [4:0]  jobcnt_r;

  // job table: {ready time, remaining time}
  logic [EW-1:0]        mem [MAX_JOBS];
  logic [EW-1:0]        rdata_r;
  logic                 mem_we;
  logic [IDXW-1:0]      mem_waddr, mem_raddr;
  logic [EW-1:0]        mem_wdata;
  logic [TIME_BITS-1:0] rd_arr, rd_rem;

  // control state
  logic [2:0]           state_r, state_nxt;
  logic                 hr_r, hr_nxt;
  logic [IDXW-1:0]      run_r, run_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [15:0]          slc_r, slc_nxt;
  logic [CNTW-1:0]      ret_r, ret_nxt;
  logic [CNTW-1:0]      lp_r, lp_nxt;
  logic                 done_r, done_nxt;
  logic [MAX_JOBS-1:0]  flags_r, flags_nxt;
  logic [CNTW-1:0]      start_r, start_nxt;
  logic [CNTW-1:0]      iss_r, iss_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [IDXW-1:0]      rd_idx_r, rd_idx_nxt;

  // pending result
  logic                 res_fin_r, res_fin_nxt;
  logic [IDXW-1:0]      res_fslot_r, res_fslot_nxt;
  logic                 res_sw_r, res_sw_nxt;
  logic [TIME_BITS-1:0] res_now_r, res_now_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic        o_run_v_r, o_run_v_nxt;
  logic [3:0]  o_run_s_r, o_run_s_nxt;
  logic        o_sw_r, o_sw_nxt;
  logic        o_fin_v_r, o_fin_v_nxt;
  logic [3:0]  o_fin_s_r, o_fin_s_nxt;
  logic        o_done_r, o_done_nxt;
  logic [31:0] o_now_r, o_now_nxt;

  // picker
  pick_ctl_t            pick_ctl;
  pick_flags_t          pick_flags;
  logic [IDXW-1:0]      min_idx, first_idx, after_idx;
  logic [TIME_BITS-1:0] pick_key;

  logic [CNTW-1:0] n_slots;
  logic [CNTW-1:0] ret_inc;
  logic [15:0]     slice_eff;

  // clamp job_count into 1..MAX_JOBS
  always_comb begin
    if (jobcnt_r == 5'd0) begin
      n_slots = CNTW'(1);
    end else if (32'(jobcnt_r) > 32'(MAX_JOBS)) begin
      n_slots = CNTW'(MAX_JOBS);
    end else begin
      n_slots = CNTW'(jobcnt_r);
    end
  end

  assign ret_inc   = ret_r + CNTW'(1);
  assign slice_eff = (slice_r == 16'd0) ? 16'd1 : slice_r;
  assign rd_arr    = rdata_r[EW-1:TIME_BITS];
  assign rd_rem    = rdata_r[TIME_BITS-1:0];
  assign pick_key  = (policy_r == POL_FIFO) ? rd_arr : rd_rem;
  assign in_ready  = (state_r == ST_IDLE);

  psf_pick #(
    .MAX_JOBS  (MAX_JOBS),
    .TIME_BITS (TIME_BITS)
  ) u_pick (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (pick_ctl),
    .idx       (rd_idx_r),
    .key       (pick_key),
    .flags     (pick_flags),
    .min_idx   (min_idx),
    .first_idx (first_idx),
    .after_idx (after_idx)
  );

  always_comb begin
    logic                 arrived;
    logic                 nx_ok;
    logic [IDXW-1:0]      nx_idx;
    logic                 sw;
    logic [15:0]          slc_base;
    logic [16:0]          slc_inc;

    arrived  = 1'b0;
    nx_ok    = 1'b0;
    nx_idx   = run_r;
    sw       = 1'b0;
    slc_base = slc_r;
    slc_inc  = 17'd0;

    state_nxt     = state_r;
    hr_nxt        = hr_r;
    run_nxt       = run_r;
    time_nxt      = time_r;
    slc_nxt       = slc_r;
    ret_nxt       = ret_r;
    lp_nxt        = lp_r;
    done_nxt      = done_r;
    flags_nxt     = flags_r;
    start_nxt     = start_r;
    iss_nxt       = iss_r;
    rd_vld_nxt    = rd_vld_r;
    rd_idx_nxt    = rd_idx_r;
    res_fin_nxt   = res_fin_r;
    res_fslot_nxt = res_fslot_r;
    res_sw_nxt    = res_sw_r;
    res_now_nxt   = res_now_r;

    mem_we    = 1'b0;
    mem_waddr = run_r;
    mem_wdata = {rd_arr, rd_rem - TIME_BITS'(1)};
    mem_raddr = run_r;
    pick_ctl  = '0;

    // drop the shown result once taken
    out_valid_nxt = out_valid_r && !out_ready;
    o_run_v_nxt   = o_run_v_r;
    o_run_s_nxt   = o_run_s_r;
    o_sw_nxt      = o_sw_r;
    o_fin_v_nxt   = o_fin_v_r;
    o_fin_s_nxt   = o_fin_s_r;
    o_done_nxt    = o_done_r;
    o_now_nxt     = o_now_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_now_nxt = time_r;
          res_fin_nxt = 1'b0;
          res_sw_nxt  = 1'b0;
          if (in_operation == OP_LOAD) begin
            // fill the next slot; ignore loads past the table end
            if (32'(lp_r) < 32'(MAX_JOBS)) begin
              mem_we    = 1'b1;
              mem_waddr = lp_r[IDXW-1:0];
              mem_wdata = {TIME_BITS'(in_ready_at), TIME_BITS'(in_run_length)};
              flags_nxt[lp_r[IDXW-1:0]] = 1'b0;
              lp_nxt    = lp_r + CNTW'(1);
            end
            state_nxt = ST_FIN;
          end else if (done_r) begin
            state_nxt = ST_FIN;
          end else begin
            mem_raddr = run_r;
            state_nxt = ST_RET;
          end
        end
      end
      ST_RET: begin
        // retire the running job when its time is spent
        if (hr_r && rd_rem == '0) begin
          hr_nxt        = 1'b0;
          res_fin_nxt   = 1'b1;
          res_fslot_nxt = run_r;
          ret_nxt       = ret_inc;
        end
        if (hr_r && rd_rem == '0 && ret_inc >= n_slots) begin
          done_nxt  = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          start_nxt      = CNTW'(run_r) + CNTW'(1);
          iss_nxt        = '0;
          rd_vld_nxt     = 1'b0;
          pick_ctl.clear = 1'b1;
          state_nxt      = ST_MOD;
        end
      end
      ST_MOD: begin
        // reduce the rotation start modulo the slots in use
        if (start_r >= n_slots) begin
          start_nxt = start_r - n_slots;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (iss_r < n_slots) begin
          mem_raddr  = iss_r[IDXW-1:0];
          iss_nxt    = iss_r + CNTW'(1);
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = iss_r[IDXW-1:0];
        end else begin
          rd_vld_nxt = 1'b0;
        end
        if (rd_vld_r) begin
          arrived             = flags_r[rd_idx_r] || (rd_arr == time_r);
          flags_nxt[rd_idx_r] = arrived;
          pick_ctl.step       = 1'b1;
          pick_ctl.elig       = arrived && (rd_rem != '0);
          pick_ctl.after      = CNTW'(rd_idx_r) >= start_r;
        end
        if (iss_r >= n_slots && !rd_vld_r) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        priority if (hr_r && (policy_r == POL_FIFO || policy_r == POL_NSJF)) begin
          nx_ok  = 1'b1;
          nx_idx = run_r;
        end else if (policy_r == POL_RR) begin
          priority if (!hr_r) begin
            nx_ok  = pick_flags.have_first;
            nx_idx = first_idx;
          end else if (slc_r != 16'd0) begin
            nx_ok  = 1'b1;
            nx_idx = run_r;
          end else if (pick_flags.have_after) begin
            nx_ok  = 1'b1;
            nx_idx = after_idx;
          end else if (pick_flags.have_first) begin
            nx_ok  = 1'b1;
            nx_idx = first_idx;
          end else begin
            nx_ok  = 1'b1;
            nx_idx = run_r;
          end
        end else begin
          nx_ok  = pick_flags.have_min;
          nx_idx = min_idx;
        end
        sw = nx_ok && (!hr_r || run_r != nx_idx);
        if (sw) begin
          hr_nxt     = 1'b1;
          run_nxt    = nx_idx;
          res_sw_nxt = 1'b1;
          slc_base   = 16'd0;
        end
        slc_inc   = {1'b0, slc_base} + 17'd1;
        slc_nxt   = (slc_inc >= {1'b0, slice_eff}) ? 16'd0 : slc_inc[15:0];
        time_nxt  = time_r + TIME_BITS'(1);
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        mem_raddr = run_r;
        state_nxt = ST_DECW;
      end
      ST_DECW: begin
        if (hr_r && rd_rem != '0) begin
          mem_we    = 1'b1;
          mem_waddr = run_r;
          mem_wdata = {rd_arr, rd_rem - TIME_BITS'(1)};
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_run_v_nxt   = hr_r;
          o_run_s_nxt   = hr_r ? 4'(run_r) : 4'd0;
          o_sw_nxt      = res_sw_r;
          o_fin_v_nxt   = res_fin_r;
          o_fin_s_nxt   = res_fin_r ? 4'(res_fslot_r) : 4'd0;
          o_done_nxt    = done_r;
          o_now_nxt     = 32'(res_now_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FIFO;
      slice_r  <= SLICE_RESET;
      jobcnt_r <= JOB_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POLICY:    policy_r <= cfg_data[1:0];
        REG_SLICE:     slice_r  <= cfg_data;
        REG_JOB_COUNT: jobcnt_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hr_r        <= 1'b0;
      run_r       <= '0;
      time_r      <= '0;
      slc_r       <= '0;
      ret_r       <= '0;
      lp_r        <= '0;
      done_r      <= 1'b0;
      flags_r     <= '0;
      iss_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hr_r        <= hr_nxt;
      run_r       <= run_nxt;
      time_r      <= time_nxt;
      slc_r       <= slc_nxt;
      ret_r       <= ret_nxt;
      lp_r        <= lp_nxt;
      done_r      <= done_nxt;
      flags_r     <= flags_nxt;
      iss_r       <= iss_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r     <= start_nxt;
    rd_idx_r    <= rd_idx_nxt;
    res_fin_r   <= res_fin_nxt;
    res_fslot_r <= res_fslot_nxt;
    res_sw_r    <= res_sw_nxt;
    res_now_r   <= res_now_nxt;
    o_run_v_r   <= o_run_v_nxt;
    o_run_s_r   <= o_run_s_nxt;
    o_sw_r      <= o_sw_nxt;
    o_fin_v_r   <= o_fin_v_nxt;
    o_fin_s_r   <= o_fin_s_nxt;
    o_done_r    <= o_done_nxt;
    o_now_r     <= o_now_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_running_valid  = o_run_v_r;
  assign out_running_slot   = o_run_s_r;
  assign out_switched       = o_sw_r;
  assign out_finished_valid = o_fin_v_r;
  assign out_finished_slot  = o_fin_s_r;
  assign out_all_done       = o_done_r;
  assign out_tick_now       = o_now_r;

endmodule

[rtl/psf_checker.sv]
// Port-level checker for the job scheduler, bound to the top level.
// Uses the assertion macros of process_scheduler_fifo_rr_sjf_defines.svh.
`include "process_scheduler_fifo_rr_sjf_defines.svh"

module psf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_running_valid,
  input logic [3:0]  out_running_slot,
  input logic        out_switched,
  input logic        out_finished_valid,
  input logic [3:0]  out_finished_slot,
  input logic        out_all_done,
  input logic [31:0] out_tick_now
);

  `PSF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_running_slot) && $stable(out_tick_now) && $stable(out_finished_slot), "result changed while stalled")
  `PSF_ASSERT_NOW(a_idle_slot, out_valid && !out_running_valid, out_running_slot == 4'd0, "running slot set with nothing running")
  `PSF_ASSERT_NOW(a_fin_slot, out_valid && !out_finished_valid, out_finished_slot == 4'd0, "finished slot set without a retirement")
  `PSF_ASSERT_NOW(a_switch_runs, out_valid && out_switched, out_running_valid, "switch reported with nothing running")
  `PSF_ASSERT_NOW(a_done_idle, out_valid && out_all_done, !out_running_valid && !out_switched, "job running after all jobs done")

endmodule

bind process_scheduler_fifo_rr_sjf psf_checker u_psf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_running_valid  (out_running_valid),
  .out_running_slot   (out_running_slot),
  .out_switched       (out_switched),
  .out_finished_valid (out_finished_valid),
  .out_finished_slot  (out_finished_slot),
  .out_all_done       (out_all_done),
  .out_tick_now       (out_tick_now)
);

[test/tb_top.sv]
// Self-checking bench for the job scheduler: loads a job table, then ticks it
// under every policy, predicting each response in-line. Depends on psf_pkg.
module tb_top;
  import psf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_TICK = 1'b1;
  localparam int   SLOTS   = 16;

  typedef struct {
    logic        op;
    logic [31:0] ready_at;
    logic [31:0] run_length;
  } sched_req_t;

  typedef struct {
    logic        running_valid;
    logic [3:0]  running_slot;
    logic        switched;
    logic        finished_valid;
    logic [3:0]  finished_slot;
    logic        all_done;
    logic [31:0] tick_now;
  } sched_rsp_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [31:0] in_ready_at;
  logic [31:0] in_run_length;
  logic        out_valid;
  logic        out_ready;
  logic        out_running_valid;
  logic [3:0]  out_running_slot;
  logic        out_switched;
  logic        out_finished_valid;
  logic [3:0]  out_finished_slot;
  logic        out_all_done;
  logic [31:0] out_tick_now;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  process_scheduler_fifo_rr_sjf dut (.*);

  // Request queue for the driver, and responses still owed by the block.
  sched_req_t request_queue[$];
  sched_rsp_t owed_responses[$];

  // Predictor copy of the job table and scheduler state.
  logic [31:0] arrive_at[SLOTS];
  logic [31:0] time_left[SLOTS];
  bit          arrived[SLOTS];
  bit          cpu_busy;
  logic [3:0]  cpu_slot;
  logic [31:0] clock_now;
  int unsigned slice_ticks;
  int unsigned retired;
  int unsigned load_ptr;
  bit          sched_done;

  // Shadow of the configuration registers.
  logic [1:0]  cur_policy;
  logic [15:0] cur_slice;
  logic [4:0]  cur_count;

  int errors;
  int ticks_seen;
  int switches_seen;
  int retires_seen;
  bit done_seen;
  bit in_taken;
  int tx_gap;
  int rx_gap;
  int rx_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb_top: errors");
    $finish;
  end

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, field, got, want);
  endtask

  function automatic int pick_shortest(int n, bit by_length);
    int pick;
    pick = -1;
    for (int i = 0; i < n; i++) begin
      if (!(arrived[i] && time_left[i] != 0)) continue;
      if (pick < 0) pick = i;
      else if (by_length ? (time_left[i] < time_left[pick]) : (arrive_at[i] < arrive_at[pick]))
        pick = i;
    end
    return pick;
  endfunction

  function automatic int pick_rotation(int n);
    int s;
    if (!cpu_busy) begin
      for (int k = 0; k < n; k++)
        if (arrived[k] && time_left[k] != 0) return k;
      return -1;
    end
    if (slice_ticks != 0) return cpu_slot;
    s = cpu_slot;
    for (int k = 0; k < n; k++) begin
      s = (s + 1) % n;
      if (arrived[s] && time_left[s] != 0) return s;
    end
    return cpu_slot;
  endfunction

  // Apply one request to the shadow scheduler and return its response.
  function automatic sched_rsp_t advance_schedule(sched_req_t rq);
    sched_rsp_t  r;
    int          n;
    int          nxt;
    int unsigned sl;
    n = (cur_count == 0) ? 1 : (cur_count > SLOTS) ? SLOTS : cur_count;
    r = '{default: '0};
    r.tick_now = clock_now;
    if (rq.op == OP_LOAD) begin
      if (load_ptr < SLOTS) begin
        arrive_at[load_ptr] = rq.ready_at;
        time_left[load_ptr] = rq.run_length;
        arrived[load_ptr] = 1'b0;
        load_ptr++;
      end
    end else if (!sched_done) begin
      if (cpu_busy && time_left[cpu_slot] == 0) begin
        r.finished_valid = 1'b1;
        r.finished_slot = cpu_slot;
        cpu_busy = 1'b0;
        retired++;
        if (retired >= n) sched_done = 1'b1;
      end
      if (!sched_done) begin
        for (int i = 0; i < n; i++)
          if (arrive_at[i] == clock_now) arrived[i] = 1'b1;
        if (cpu_busy && (cur_policy == POL_FIFO || cur_policy == POL_NSJF)) nxt = cpu_slot;
        else if (cur_policy == POL_FIFO) nxt = pick_shortest(n, 1'b0);
        else if (cur_policy == POL_RR) nxt = pick_rotation(n);
        else nxt = pick_shortest(n, 1'b1);
        if (nxt >= 0 && (!cpu_busy || cpu_slot != nxt)) begin
          cpu_busy = 1'b1;
          cpu_slot = nxt;
          r.switched = 1'b1;
          slice_ticks = 0;
        end
        if (cpu_busy && time_left[cpu_slot] != 0) time_left[cpu_slot]--;
        clock_now++;
        sl = (cur_slice == 0) ? 1 : cur_slice;
        slice_ticks++;
        if (slice_ticks >= sl) slice_ticks = 0;
      end
    end
    r.running_valid = cpu_busy;
    r.running_slot = cpu_busy ? cpu_slot : 4'd0;
    r.all_done = sched_done;
    return r;
  endfunction

  // Driver: present the next request at the falling edge, after its own gap.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the request until the block takes it
    end else begin
      in_taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (request_queue.size() > 0) begin
        sched_req_t rq;
        rq = request_queue.pop_front();
        in_operation <= rq.op;
        in_ready_at <= rq.ready_at;
        in_run_length <= rq.run_length;
        in_valid <= 1'b1;
        tx_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: a long hold-off when asked, otherwise a random gap per response.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted request, check each accepted response.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sched_req_t rq;
        rq.op = in_operation;
        rq.ready_at = in_ready_at;
        rq.run_length = in_run_length;
        owed_responses.push_back(advance_schedule(rq));
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (owed_responses.size() == 0) begin
          report_mismatch("unexpected response", 32'd0, 32'd0);
        end else begin
          sched_rsp_t w;
          w = owed_responses.pop_front();
          if (out_running_valid !== w.running_valid)
            report_mismatch("running_valid", out_running_valid, w.running_valid);
          if (out_running_slot !== w.running_slot)
            report_mismatch("running_slot", out_running_slot, w.running_slot);
          if (out_switched !== w.switched)
            report_mismatch("switched", out_switched, w.switched);
          if (out_finished_valid !== w.finished_valid)
            report_mismatch("finished_valid", out_finished_valid, w.finished_valid);
          if (out_finished_slot !== w.finished_slot)
            report_mismatch("finished_slot", out_finished_slot, w.finished_slot);
          if (out_all_done !== w.all_done)
            report_mismatch("all_done", out_all_done, w.all_done);
          if (out_tick_now !== w.tick_now)
            report_mismatch("tick_now", out_tick_now, w.tick_now);
          if (w.switched) switches_seen++;
          if (w.finished_valid) retires_seen++;
          if (w.all_done) done_seen = 1'b1;
        end
        rx_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
      end
    end
  end

  task automatic push_request(logic op, logic [31:0] ra, logic [31:0] rl);
    sched_req_t rq;
    rq.op = op;
    rq.ready_at = ra;
    rq.run_length = rl;
    request_queue.push_back(rq);
    if (op == OP_TICK) ticks_seen++;
  endtask

  // Wait until every request is through, then let the block go quiet.
  task automatic drain;
    while (request_queue.size() > 0 || in_valid || owed_responses.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_POLICY) cur_policy = val[1:0];
    else if (idx == REG_SLICE) cur_slice = val;
    else if (idx == REG_JOB_COUNT) cur_count = val[4:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly ticks; now and then a load, which the full table ignores.
  task automatic tick_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0) push_request(OP_LOAD, $urandom, $urandom);
      else push_request(OP_TICK, $urandom, $urandom);
    end
    drain();
  endtask

  initial begin
    logic [31:0] ra;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_LOAD;
    in_ready_at = '0;
    in_run_length = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_POLICY;
    cfg_data = '0;
    in_taken = 1'b0;
    tx_gap = 0;
    rx_gap = 0;
    rx_hold = 0;
    errors = 0;
    ticks_seen = 0;
    switches_seen = 0;
    retires_seen = 0;
    done_seen = 1'b0;
    cpu_busy = 1'b0;
    cpu_slot = '0;
    clock_now = '0;
    slice_ticks = 0;
    retired = 0;
    load_ptr = 0;
    sched_done = 1'b0;
    cur_policy = POL_FIFO;
    cur_slice = SLICE_RESET;
    cur_count = JOB_COUNT_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      arrive_at[i] = '0;
      time_left[i] = '0;
      arrived[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill every slot before the first tick. Slot 0 is a one-tick job tied
    // with slot 1 on ready time; slot 14 never arrives and slot 15 has no
    // run time, so neither ever retires.
    ra = 0;
    for (int i = 0; i < 14; i++) begin
      if (i > 1) ra = ra + $urandom_range(0, 25);
      push_request(OP_LOAD, ra, (i == 0) ? 32'd1 : $urandom_range(1, 80));
    end
    push_request(OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(OP_LOAD, 32'd5, 32'd0);
    // Table full: these loads change nothing.
    push_request(OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(OP_LOAD, 32'd0, 32'd0);
    for (int i = 0; i < 5; i++) push_request(OP_TICK, 32'd0, 32'd0);

    // Reset configuration first, with the receiver held off so the block backs up.
    rx_hold = 300;
    tick_phase(110);
    write_reg(REG_POLICY, POL_RR);
    write_reg(REG_SLICE, 16'd1);
    write_reg(REG_JOB_COUNT, 16'd31);
    tick_phase(110);
    write_reg(REG_SLICE, 16'd3);
    write_reg(REG_JOB_COUNT, 16'd16);
    tick_phase(110);
    write_reg(REG_POLICY, POL_NSJF);
    tick_phase(110);
    write_reg(REG_POLICY, POL_PSJF);
    tick_phase(110);
    write_reg(REG_POLICY, POL_RR);
    write_reg(REG_SLICE, 16'd0);
    tick_phase(100);
    write_reg(REG_SLICE, 16'hFFFF);
    tick_phase(100);
    write_reg(REG_POLICY, POL_FIFO);
    write_reg(REG_SLICE, 16'd7);
    tick_phase(110);
    // Shrink the table to one slot so the next retirement ends the schedule.
    write_reg(REG_JOB_COUNT, 16'd0);
    tick_phase(100);

    drain();
    $display("covered %0d ticks over four policies, %0d switches, %0d retirements",
             ticks_seen, switches_seen, retires_seen);
    $display("schedule completion %s", done_seen ? "reached" : "not reached");
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/psf_pkg.sv
rtl/psf_pick.sv
rtl/process_scheduler_fifo_rr_sjf.sv
rtl/psf_checker.sv
test/tb_top.sv
